@@ rtl/mie_pkg.sv @@
// Package for the modular inverse block: payload types, command and status types, defaults.
`default_nettype none

package mie_pkg;

    // Default datapath width; operands are WIDTH-1 bits unsigned.
    localparam int DEF_WIDTH = 32;

    // Width of every numeric field on the ports.
    localparam int FIELD_W = 31;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] modulus;
    } mie_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        logic [FIELD_W-1:0] common_divisor;
        logic               modulus_zero;
    } mie_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new transaction
        logic div_init;    // prime the divider
        logic div_sel_red; // divider works on the final reduction, not on a Euclid step
        logic div_step;    // retire one quotient bit
        logic update;      // advance the remainder and coefficient sequences
        logic fix;         // bring the coefficient into the non-negative range
        logic take_rem;    // coefficient takes the remainder of the reduction
    } mie_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic m_zero;
        logic cnt_zero;
        logic rem_zero;
        logic s_ge_m;
    } mie_status_t;

endpackage

`default_nettype wire

@@ rtl/mie_datapath.sv @@
// Datapath of the modular inverse block: Euclid registers, shared shift-subtract divider.
`default_nettype none

module mie_datapath #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire mie_pkg::mie_req_t  req,
    input  wire mie_pkg::mie_cmd_t  cmd,
    output mie_pkg::mie_status_t    status,
    output mie_pkg::mie_res_t       res
);
    import mie_pkg::*;

    localparam int OW       = WIDTH - 1;
    localparam int CNT_W    = $clog2(OW);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(OW - 1);

    logic [OW-1:0]    n1_reg, n2_reg, m_reg;
    logic [OW-1:0]    rem_reg, dvd_reg, dsr_reg;
    logic [WIDTH-1:0] a_reg, b_reg, s_reg, prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             mz_reg;

    logic [OW:0]      shifted;
    logic [OW:0]      trial;
    logic             qbit;
    logic [OW-1:0]    rem_next;
    logic [WIDTH-1:0] prod_next;
    logic [WIDTH-1:0] m_ext;
    logic [WIDTH-1:0] sum_fix;
    logic [WIDTH-1:0] s_fix;

    // One restoring division step; the product b*q is built alongside, MSB first.
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[OW-1]};
        trial     = shifted - {1'b0, dsr_reg};
        qbit      = ~trial[OW];
        rem_next  = qbit ? trial[OW-1:0] : shifted[OW-1:0];
        prod_next = {prod_reg[WIDTH-2:0], 1'b0} + (qbit ? b_reg : '0);
        m_ext     = {1'b0, m_reg};
        sum_fix   = b_reg + m_ext;
        if (b_reg[WIDTH-1])
        begin
            s_fix = sum_fix[WIDTH-1] ? '0 : sum_fix;
        end
        else
        begin
            s_fix = b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n1_reg <= OW'(req.value);
            n2_reg <= OW'(req.modulus);
            m_reg  <= OW'(req.modulus);
            a_reg  <= WIDTH'(1);
            b_reg  <= '0;
            s_reg  <= '0;
            mz_reg <= (OW'(req.modulus) == '0);
        end
        else if (cmd.div_init)
        begin
            rem_reg  <= '0;
            dvd_reg  <= cmd.div_sel_red ? s_reg[OW-1:0] : n1_reg;
            dsr_reg  <= cmd.div_sel_red ? m_reg : n2_reg;
            prod_reg <= '0;
            cnt_reg  <= CNT_INIT;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[OW-2:0], 1'b0};
            prod_reg <= prod_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
        else if (cmd.update)
        begin
            a_reg  <= b_reg;
            b_reg  <= a_reg - prod_reg;
            n1_reg <= n2_reg;
            n2_reg <= rem_reg;
        end
        else if (cmd.fix)
        begin
            s_reg <= s_fix;
        end
        else if (cmd.take_rem)
        begin
            s_reg <= {1'b0, rem_reg};
        end
    end

    assign status.m_zero   = mz_reg;
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.rem_zero = (rem_reg == '0);
    assign status.s_ge_m   = (s_reg >= m_ext);

    assign res.inverse        = FIELD_W'(s_reg);
    assign res.common_divisor = FIELD_W'(n2_reg);
    assign res.modulus_zero   = mz_reg;

endmodule

`default_nettype wire

@@ rtl/mie_ctrl.sv @@
// Controller state machine of the modular inverse block.
`default_nettype none

module mie_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire mie_pkg::mie_status_t status,
    output mie_pkg::mie_cmd_t         cmd,
    output logic                      busy,
    output logic                      done
);
    import mie_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHKM  = 4'd1;
    localparam logic [3:0] S_DINIT = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_FIX   = 4'd6;
    localparam logic [3:0] S_RCHK  = 4'd7;
    localparam logic [3:0] S_RINIT = 4'd8;
    localparam logic [3:0] S_RDIV  = 4'd9;
    localparam logic [3:0] S_RTAKE = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_CHKM;
                end
            end
            S_CHKM:  state_next = status.m_zero ? S_DONE : S_DINIT;
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:  state_next = status.rem_zero ? S_FIX : S_UPD;
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DINIT;
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_RCHK;
            end
            S_RCHK:  state_next = status.s_ge_m ? S_RINIT : S_DONE;
            S_RINIT:
            begin
                cmd.div_init    = 1'b1;
                cmd.div_sel_red = 1'b1;
                state_next      = S_RDIV;
            end
            S_RDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = S_RTAKE;
                end
            end
            S_RTAKE:
            begin
                cmd.take_rem = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

@@ rtl/modular_inverse_ext_euclid.sv @@
// Top level of the modular inverse block: controller, datapath and checks.
`default_nettype none

// Computes the modular inverse of value modulo modulus by the extended Euclidean
// algorithm, and reports the gcd so that the caller can tell whether the inverse
// exists (it does when common_divisor is 1). A transaction is accepted at a rising
// edge where start is high and busy is low; busy then stays high until the result
// has been shown. The result is on res for exactly one cycle, marked by done, and
// the receiver cannot hold it off, so it must capture it in that cycle. A zero
// modulus sets modulus_zero with the other fields at zero, and the controller goes
// from its modulus check straight to the result. Otherwise each Euclid step spends
// almost all of its time in the single shared shift-subtract divider, which retires
// one quotient bit per cycle; the product needed for the Bezout coefficient is built
// during the same division, so no multiplier is needed. When the fixed coefficient
// is not below the modulus, a final reduction on the same divider follows the last
// step. There is no state between transactions.

module modular_inverse_ext_euclid #(
    parameter int WIDTH = mie_pkg::DEF_WIDTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mie_pkg::mie_req_t req,
    output logic                   busy,
    output logic                   done,
    output mie_pkg::mie_res_t      res
);
    import mie_pkg::*;

    mie_cmd_t    cmd;
    mie_status_t status;

    // The controller sequences Euclid steps and the final reduction.
    mie_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the remainder pair, the coefficients and the divider.
    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk    (clk),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .res    (res)
    );

    // A new transaction always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The result is shown for one cycle only, after which the block is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // A zero modulus gives zero inverse and zero gcd.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.modulus_zero) |-> (res.inverse == '0 && res.common_divisor == '0))
        else $error("zero modulus result not cleared");

    // With a non-zero modulus the gcd is non-zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.modulus_zero) |-> (res.common_divisor != '0))
        else $error("gcd of zero reported for non-zero modulus");

    // The datapath is never given two of its commands in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_init, cmd.div_step, cmd.update, cmd.fix, cmd.take_rem}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire
